[rtl/core/osa_pkg.sv]
// ----------------------------------------------------------------------------
// osa_pkg: shared types and constants of the operand stack ALU
// Operation codes, error codes, sequencer states and the ALU command struct.
// ----------------------------------------------------------------------------
package osa_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned DATA_W          = 64;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0,
    OP_POP  = 4'd1,
    OP_PEEK = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_MUL  = 4'd5,
    OP_DIV  = 4'd6,
    OP_MOD  = 4'd7,
    OP_POW  = 4'd8,
    OP_INCR = 4'd9,
    OP_DECR = 4'd10,
    OP_OR   = 4'd11,
    OP_AND  = 4'd12,
    OP_NOT  = 4'd13,
    OP_REV  = 4'd14,
    OP_NONE = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_ZERODIV   = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_LAT_B,
    ST_ALU_GO,
    ST_ALU_WAIT,
    ST_WRITE,
    ST_REV_RD_LO,
    ST_REV_RD_HI,
    ST_REV_WR_LO,
    ST_REV_WR_HI,
    ST_REV_TOP,
    ST_REV_TOP_LAT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_POW_NEXT,
    A_DONE
  } alu_state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

[rtl/core/osa_alu.sv]
// ----------------------------------------------------------------------------
// osa_alu: shared multi-cycle arithmetic unit
// One 64-bit shift-add path iterated for multiply and power, a restoring
// divider for divide and modulo; add, subtract, increment, decrement and
// logic finish in one step.
// ----------------------------------------------------------------------------
module osa_alu (
  input  logic                 clk,
  input  logic                 rst,
  input  osa_pkg::alu_cmd_t    cmd,
  input  logic [63:0]          a,
  input  logic [63:0]          b,
  output osa_pkg::alu_stat_t   stat,
  output logic [63:0]          result
);

  osa_pkg::alu_state_t st, st_next;
  osa_pkg::op_t op_r;
  logic [63:0] mx;       // multiplicand, shifted left each step
  logic [63:0] my;       // multiplier, shifted right each step
  logic [63:0] prod;
  logic [63:0] base;     // power: running square of the base
  logic [63:0] ex;       // power: exponent bits not yet used
  logic [63:0] pacc;     // power: accumulated product
  logic        pw_sq;    // power: next step squares the base
  logic        pw_dst;   // power: running multiply updates the base
  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic [5:0]  cnt;
  logic        neg_q;
  logic        neg_r;

  logic [63:0] a_mag, b_mag;
  logic [63:0] prod_next;
  logic        mul_last;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic [63:0] quo_next;
  logic [63:0] rem_next;

  assign a_mag     = a[63] ? (64'd0 - a) : a;
  assign b_mag     = b[63] ? (64'd0 - b) : b;
  assign prod_next = my[0] ? prod + mx : prod;
  assign mul_last  = (my[63:1] == 63'd0);
  assign rem_sh    = {rem, quo[63]};
  assign rem_sub   = rem_sh - {1'b0, dvs};
  assign quo_next  = {quo[62:0], ~rem_sub[64]};
  assign rem_next  = rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];

  always_comb begin
    st_next = st;
    unique case (st)
      osa_pkg::A_IDLE: if (cmd.start) begin
        unique case (cmd.op)
          osa_pkg::OP_MUL:                  st_next = osa_pkg::A_MUL;
          osa_pkg::OP_DIV, osa_pkg::OP_MOD: st_next = osa_pkg::A_DIV;
          osa_pkg::OP_POW: st_next = b[63] ? osa_pkg::A_DONE : osa_pkg::A_POW_NEXT;
          default:                          st_next = osa_pkg::A_DONE;
        endcase
      end
      osa_pkg::A_MUL: if (mul_last) begin
        st_next = (op_r == osa_pkg::OP_POW) ? osa_pkg::A_POW_NEXT : osa_pkg::A_DONE;
      end
      osa_pkg::A_DIV: if (&cnt) st_next = osa_pkg::A_DONE;
      osa_pkg::A_POW_NEXT: begin
        priority if (pw_sq)
          st_next = (ex[63:1] == 63'd0) ? osa_pkg::A_DONE : osa_pkg::A_MUL;
        else if (ex[0])
          st_next = osa_pkg::A_MUL;
      end
      osa_pkg::A_DONE: st_next = osa_pkg::A_IDLE;
      default: st_next = osa_pkg::A_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (st != osa_pkg::A_IDLE) && (st != osa_pkg::A_DONE);
    stat.done = (st == osa_pkg::A_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= osa_pkg::A_IDLE;
    end else begin
      st <= st_next;
      unique case (st)
        osa_pkg::A_IDLE: if (cmd.start) begin
          op_r <= cmd.op;
          cnt  <= '0;
          unique case (cmd.op)
            osa_pkg::OP_ADD:  result <= a + b;
            osa_pkg::OP_SUB:  result <= a - b;
            osa_pkg::OP_INCR: result <= a + 64'd1;
            osa_pkg::OP_DECR: result <= a - 64'd1;
            osa_pkg::OP_OR:   result <= {63'd0, (a != 64'd0) || (b != 64'd0)};
            osa_pkg::OP_AND:  result <= {63'd0, (a != 64'd0) && (b != 64'd0)};
            osa_pkg::OP_NOT:  result <= {63'd0, a == 64'd0};
            osa_pkg::OP_MUL: begin
              mx <= a; my <= b; prod <= '0;
            end
            osa_pkg::OP_DIV, osa_pkg::OP_MOD: begin
              quo <= a_mag; dvs <= b_mag; rem <= '0;
              neg_q <= a[63] ^ b[63]; neg_r <= a[63];
            end
            osa_pkg::OP_POW: begin
              if (b[63]) begin
                priority if (a == 64'd1) result <= 64'd1;
                else if (&a)            result <= b[0] ? {64{1'b1}} : 64'd1;
                else                    result <= 64'd0;
              end else begin
                base <= a; ex <= b; pacc <= 64'd1; pw_sq <= 1'b0;
              end
            end
            default: result <= '0;
          endcase
        end
        osa_pkg::A_MUL: begin
          // shift-add, one multiplier bit per cycle, stops when no bits remain
          prod <= prod_next;
          mx   <= mx << 1;
          my   <= my >> 1;
          if (mul_last) begin
            priority if (op_r != osa_pkg::OP_POW) result <= prod_next;
            else if (pw_dst)                      base   <= prod_next;
            else                                  pacc   <= prod_next;
          end
        end
        osa_pkg::A_DIV: begin
          // restoring division, one quotient bit per cycle
          quo <= quo_next;
          rem <= rem_next;
          cnt <= cnt + 6'd1;
          if (&cnt) begin
            if (op_r == osa_pkg::OP_DIV) result <= neg_q ? 64'd0 - quo_next : quo_next;
            else                         result <= neg_r ? 64'd0 - rem_next : rem_next;
          end
        end
        osa_pkg::A_POW_NEXT: begin
          // per exponent bit: acc *= base if set, then base *= base
          prod <= '0;
          if (pw_sq) begin
            if (ex[63:1] == 63'd0) begin
              result <= pacc;
            end else begin
              mx <= base; my <= base; pw_dst <= 1'b1;
              ex <= ex >> 1;
              pw_sq <= 1'b0;
            end
          end else begin
            pw_sq <= 1'b1;
            if (ex[0]) begin
              mx <= pacc; my <= base; pw_dst <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/operand_stack_alu.sv]
// ----------------------------------------------------------------------------
// operand_stack_alu: operand stack with a shared iterative ALU
// One operation per item on a stack of 64-bit signed entries.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: op[3:0], push_value[67:4]
// m_axis   out  tdata: result_value[63:0], depth_after[72:64], error_code[74:73]
//
// Mul, div and mod iterate on the shared ALU, one bit per cycle. Power runs up
// to two serial multiplies per exponent bit. Reverse swaps each entry pair by
// reading the low entry, reading the high entry, then writing the low and the
// high entry, on a stack memory with one read and one write port. Reset clears
// the count and the state only; the stack memory is not cleared.
// s_axis_tready is low from acceptance until the result item is taken.
// ----------------------------------------------------------------------------
module operand_stack_alu #(
  parameter int unsigned STACK_DEPTH = osa_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // op, push_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // result_value, depth_after, error_code
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  osa_pkg::state_t state, state_next;
  osa_pkg::op_t    op;
  logic [63:0]     push_value;
  logic [CW-1:0]   count;
  logic [63:0]     a_reg, b_reg, res_reg, lo_val;
  logic [1:0]      err;
  logic [AW-1:0]   lo, hi;
  logic [63:0]     mem [STACK_DEPTH];
  logic [63:0]     rd_data;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [63:0]     wr_data;
  logic            wr_en;
  osa_pkg::alu_cmd_t  cmd;
  osa_pkg::alu_stat_t alu_stat;
  logic [63:0]     alu_res;
  logic [1:0]      need;
  logic            in_acc;
  logic [CW-1:0]   count_m1, count_m2;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  osa_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .a      (a_reg),
    .b      (b_reg),
    .stat   (alu_stat),
    .result (alu_res)
  );

  always_comb begin
    unique case (op)
      osa_pkg::OP_POP, osa_pkg::OP_PEEK, osa_pkg::OP_INCR,
      osa_pkg::OP_DECR, osa_pkg::OP_NOT: need = 2'd1;
      osa_pkg::OP_PUSH, osa_pkg::OP_REV, osa_pkg::OP_NONE: need = 2'd0;
      default: need = 2'd2;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      osa_pkg::ST_IDLE: if (in_acc) state_next = osa_pkg::ST_RD_A;
      osa_pkg::ST_RD_A: begin
        priority if (op == osa_pkg::OP_PUSH || op == osa_pkg::OP_NONE ||
                     CW'(need) > count)
          state_next = osa_pkg::ST_DONE;
        else if (op == osa_pkg::OP_REV)
          state_next = (count > CW'(1)) ? osa_pkg::ST_REV_RD_LO
                     : (count == CW'(1)) ? osa_pkg::ST_REV_TOP : osa_pkg::ST_DONE;
        else state_next = osa_pkg::ST_RD_B;
      end
      osa_pkg::ST_RD_B:   state_next = osa_pkg::ST_LAT_B;
      osa_pkg::ST_LAT_B: begin
        priority if (op == osa_pkg::OP_POP || op == osa_pkg::OP_PEEK)
          state_next = osa_pkg::ST_DONE;
        else if ((op == osa_pkg::OP_DIV || op == osa_pkg::OP_MOD) && rd_data == 64'd0)
          state_next = osa_pkg::ST_DONE;
        else state_next = osa_pkg::ST_ALU_GO;
      end
      osa_pkg::ST_ALU_GO:   state_next = osa_pkg::ST_ALU_WAIT;
      osa_pkg::ST_ALU_WAIT: if (alu_stat.done) state_next = osa_pkg::ST_WRITE;
      osa_pkg::ST_WRITE:    state_next = osa_pkg::ST_DONE;
      osa_pkg::ST_REV_RD_LO: state_next = osa_pkg::ST_REV_RD_HI;
      osa_pkg::ST_REV_RD_HI: state_next = osa_pkg::ST_REV_WR_LO;
      osa_pkg::ST_REV_WR_LO: state_next = osa_pkg::ST_REV_WR_HI;
      osa_pkg::ST_REV_WR_HI:
        state_next = ({1'b0, hi} > {1'b0, lo} + (AW+1)'(2)) ?
                     osa_pkg::ST_REV_RD_LO : osa_pkg::ST_REV_TOP;
      osa_pkg::ST_REV_TOP:     state_next = osa_pkg::ST_REV_TOP_LAT;
      osa_pkg::ST_REV_TOP_LAT: state_next = osa_pkg::ST_DONE;
      osa_pkg::ST_DONE: if (m_axis_tready) state_next = osa_pkg::ST_IDLE;
      default: state_next = osa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = count_m1[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = count_m1[AW-1:0];
    wr_data = res_reg;
    cmd.start = (state == osa_pkg::ST_ALU_GO);
    cmd.op    = op;
    unique case (state)
      osa_pkg::ST_RD_A: begin
        if (op == osa_pkg::OP_PUSH && count < CW'(STACK_DEPTH)) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
          wr_data = push_value;
        end
      end
      osa_pkg::ST_RD_B: rd_addr = count_m2[AW-1:0];
      osa_pkg::ST_REV_RD_LO: rd_addr = lo;
      osa_pkg::ST_REV_RD_HI: rd_addr = hi;
      osa_pkg::ST_REV_WR_LO: begin wr_en = 1'b1; wr_addr = lo; wr_data = rd_data; end
      osa_pkg::ST_REV_WR_HI: begin wr_en = 1'b1; wr_addr = hi; wr_data = lo_val; end
      osa_pkg::ST_WRITE: begin
        // count already dropped for binary ops, so the new top is count - 1
        wr_en   = 1'b1;
        wr_data = alu_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= osa_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        osa_pkg::ST_IDLE: if (in_acc) begin
          op         <= osa_pkg::op_t'(s_axis_tdata[3:0]);
          push_value <= s_axis_tdata[67:4];
          err        <= osa_pkg::ERR_OK;
          res_reg    <= '0;
        end
        osa_pkg::ST_RD_A: begin
          lo <= '0;
          hi <= count_m1[AW-1:0];
          if (op == osa_pkg::OP_PUSH) begin
            if (count >= CW'(STACK_DEPTH)) err <= osa_pkg::ERR_OVERFLOW;
            else begin count <= count + CW'(1); res_reg <= push_value; end
          end else if (op != osa_pkg::OP_REV && op != osa_pkg::OP_NONE &&
                       CW'(need) > count) begin
            err <= osa_pkg::ERR_UNDERFLOW;
          end
        end
        osa_pkg::ST_RD_B: a_reg <= rd_data;
        osa_pkg::ST_LAT_B: begin
          b_reg <= rd_data;
          if (op == osa_pkg::OP_POP) begin res_reg <= a_reg; count <= count_m1; end
          if (op == osa_pkg::OP_PEEK) res_reg <= a_reg;
          if ((op == osa_pkg::OP_DIV || op == osa_pkg::OP_MOD) && rd_data == 64'd0)
            err <= osa_pkg::ERR_ZERODIV;
        end
        osa_pkg::ST_ALU_WAIT: if (alu_stat.done) begin
          res_reg <= alu_res;
          if (need == 2'd2) count <= count_m1;
        end
        osa_pkg::ST_REV_RD_HI: lo_val <= rd_data;
        osa_pkg::ST_REV_WR_HI: begin lo <= lo + AW'(1); hi <= hi - AW'(1); end
        osa_pkg::ST_REV_TOP_LAT: res_reg <= rd_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == osa_pkg::ST_IDLE);
  assign m_axis_tvalid = (state == osa_pkg::ST_DONE);
  assign m_axis_tdata  = {5'd0, err, 9'(count), res_reg};

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH)) else $error("count out of range");
  a_err_zero_res: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && err != osa_pkg::ERR_OK) |-> res_reg == 64'd0)
    else $error("error with nonzero result");

endmodule
